[rtl/cwe_pkg.sv]
// Package for the cassette wave encoder: phase codes, register indexes,
// framing constants and the structs shared by the RTL modules.
// No dependencies.
package cwe_pkg;

    // Sample and byte widths
    localparam int unsigned SAMPLE_W  = 8;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned HEADER_W  = 12;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 12;

    // Framing bytes
    localparam logic [BYTE_W-1:0] LEADER_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'h3C;
    localparam logic [BYTE_W-1:0] TYPE_EOF_LO = 8'h00;
    localparam logic [BYTE_W-1:0] TYPE_EOF_HI = 8'hFF;

    // Register reset values
    localparam logic [HEADER_W-1:0] HEADER_SAMPLES_RST = 12'd3000;
    localparam logic [7:0]          LEADER_BYTES_RST   = 8'd128;
    localparam logic [7:0]          HIGH_LEVEL_RST     = 8'h10;
    localparam logic [7:0]          LOW_LEVEL_RST      = 8'hF0;
    localparam logic [7:0]          IDLE_LEVEL_RST     = 8'h80;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_SAMPLES = 3'd0,
        REG_LEADER_BYTES   = 3'd1,
        REG_HIGH_LEVEL     = 3'd2,
        REG_LOW_LEVEL      = 3'd3,
        REG_IDLE_LEVEL     = 3'd4
    } cfg_idx_t;

    // Framing phases
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SYNC   = 3'd1,
        PH_TYPE   = 3'd2,
        PH_LEN    = 3'd3,
        PH_BLOCK  = 3'd4,
        PH_SUM    = 3'd5,
        PH_END    = 3'd6
    } phase_t;

    // Configuration values as seen by the core
    typedef struct packed {
        logic [HEADER_W-1:0] header_samples;
        logic [7:0]          leader_bytes;
        logic [SAMPLE_W-1:0] high_level;
        logic [SAMPLE_W-1:0] low_level;
        logic [SAMPLE_W-1:0] idle_level;
    } cfg_t;

    // Encoder state
    typedef struct packed {
        phase_t              phase;
        logic [HEADER_W-1:0] header_left;
        logic [7:0]          leader_left;
        logic                gen_busy;
        logic [BYTE_W-1:0]   cur_byte;
        logic [BYTE_W-1:0]   queued_byte;
        logic                queued_valid;
        logic [2:0]          bit_index;
        logic [1:0]          sub_index;
        logic [BYTE_W-1:0]   block_type;
        logic [BYTE_W-1:0]   block_left;
    } state_t;

    // One result transaction
    typedef struct packed {
        logic                sample_valid;
        logic [SAMPLE_W-1:0] sample;
        logic                byte_taken;
    } result_t;

endpackage

[rtl/cwe_req_if.sv]
// Request channel interface: one sample request carrying an optional file byte.
// Depends on cwe_pkg.
interface cwe_req_if;
    logic                        valid;
    logic                        ready;
    logic                        byte_valid;
    logic [cwe_pkg::BYTE_W-1:0]  in_byte;

    modport source (output valid, output byte_valid, output in_byte, input ready);
    modport sink   (input valid, input byte_valid, input in_byte, output ready);
endinterface

[rtl/cwe_res_if.sv]
// Result channel interface: one audio sample and the byte-consumed flag.
// Depends on cwe_pkg.
interface cwe_res_if;
    logic                          valid;
    logic                          ready;
    logic                          sample_valid;
    logic [cwe_pkg::SAMPLE_W-1:0]  sample;
    logic                          byte_taken;

    modport source (output valid, output sample_valid, output sample, output byte_taken,
                    input ready);
    modport sink   (input valid, input sample_valid, input sample, input byte_taken,
                    output ready);
endinterface

[rtl/cwe_cfg_if.sv]
// Configuration write channel interface: register index and write data.
// Depends on cwe_pkg.
interface cwe_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cwe_pkg::CFG_IDX_W-1:0]  index;
    logic [cwe_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/cassette_wave_encoder_top.sv]
// Top level of the cassette wave encoder: configuration bank, framing core
// and result register. Depends on cwe_pkg, the channel interfaces, cwe_cfg, cwe_core.
//
//   channel | role   | payload                          | transaction
//   --------+--------+----------------------------------+-----------------------
//   req     | sink   | byte_valid, in_byte              | valid & ready
//   res     | source | sample_valid, sample, byte_taken | valid & ready
//   cfg     | sink   | index, data                      | valid & ready (always)
//
// The phase action and sample selection sit between the state registers and the result
// register, so a request is taken every cycle while res is not stalled.
// The result register frees as it is read, so req stays ready while res is taken.
// A stall on res holds the result and blocks req until the result is taken.
// Reset returns the configuration registers to their defaults and the framing to the header phase.
module cassette_wave_encoder_top (
    input  logic       clk,
    input  logic       rst_n,
    cwe_req_if.sink    req,
    cwe_res_if.source  res,
    cwe_cfg_if.sink    cfg
);

    cwe_pkg::cfg_t    cfg_val;
    cwe_pkg::result_t result;
    cwe_pkg::result_t res_data_reg;
    logic             res_valid_reg;
    logic             res_valid_next;
    logic             step;

    // Take a request when the result register is empty or being read
    assign req.ready = !res_valid_reg || res.ready;
    assign step      = req.valid && req.ready;

    cwe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    cwe_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_valid (req.byte_valid),
        .in_byte    (req.in_byte),
        .cfg_val    (cfg_val),
        .result     (result)
    );

    // Result valid: set on a request, clear once read
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (step)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_data_reg <= result;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.sample_valid = res_data_reg.sample_valid;
    assign res.sample       = res_data_reg.sample;
    assign res.byte_taken   = res_data_reg.byte_taken;

endmodule

[rtl/cwe_cfg.sv]
// Configuration register bank of the cassette wave encoder.
// Depends on cwe_pkg and cwe_cfg_if.
module cwe_cfg (
    input  logic           clk,
    input  logic           rst_n,
    cwe_cfg_if.sink        cfg,
    output cwe_pkg::cfg_t  cfg_val
);

    cwe_pkg::cfg_t cfg_reg;
    cwe_pkg::cfg_t cfg_next;

    // Always take writes
    assign cfg.ready = 1'b1;
    assign cfg_val   = cfg_reg;

    // Decode the write; drop indexes beyond the register list
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                cwe_pkg::REG_HEADER_SAMPLES: cfg_next.header_samples = cfg.data;
                cwe_pkg::REG_LEADER_BYTES:   cfg_next.leader_bytes   = cfg.data[7:0];
                cwe_pkg::REG_HIGH_LEVEL:     cfg_next.high_level     = cfg.data[7:0];
                cwe_pkg::REG_LOW_LEVEL:      cfg_next.low_level      = cfg.data[7:0];
                cwe_pkg::REG_IDLE_LEVEL:     cfg_next.idle_level     = cfg.data[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_samples <= cwe_pkg::HEADER_SAMPLES_RST;
            cfg_reg.leader_bytes   <= cwe_pkg::LEADER_BYTES_RST;
            cfg_reg.high_level     <= cwe_pkg::HIGH_LEVEL_RST;
            cfg_reg.low_level      <= cwe_pkg::LOW_LEVEL_RST;
            cfg_reg.idle_level     <= cwe_pkg::IDLE_LEVEL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/cwe_core.sv]
// Framing state and single-pass step logic of the cassette wave encoder:
// runs the phase action, then produces at most one FSK sample per request.
// Depends on cwe_pkg.
module cwe_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        byte_valid,
    input  logic [cwe_pkg::BYTE_W-1:0]  in_byte,
    input  cwe_pkg::cfg_t               cfg_val,
    output cwe_pkg::result_t            result
);

    cwe_pkg::state_t state_reg;
    cwe_pkg::state_t state_next;

    // Phase action followed by sample generation
    always_comb
    begin
        cwe_pkg::state_t s;
        logic            pend;
        logic            taken;
        logic            cur_bit;
        logic            last;
        logic [cwe_pkg::SAMPLE_W-1:0] smp;

        s       = state_reg;
        taken   = 1'b0;
        smp     = '0;
        cur_bit = 1'b0;
        last    = 1'b0;

        pend = (s.header_left != '0) || s.gen_busy || (s.leader_left != '0) || s.queued_valid;

        // Advance the framing phase when the generator is idle and a byte is offered
        if (!pend && byte_valid)
        begin
            case (s.phase)
                cwe_pkg::PH_HEADER:
                begin
                    s.header_left = cfg_val.header_samples;
                    s.leader_left = cfg_val.leader_bytes;
                    s.phase       = cwe_pkg::PH_SYNC;
                end
                cwe_pkg::PH_SYNC:
                begin
                    taken = 1'b1;
                    if (in_byte == cwe_pkg::SYNC_BYTE)
                    begin
                        s.cur_byte     = cwe_pkg::LEADER_BYTE;
                        s.gen_busy     = 1'b1;
                        s.bit_index    = '0;
                        s.sub_index    = '0;
                        s.queued_byte  = cwe_pkg::SYNC_BYTE;
                        s.queued_valid = 1'b1;
                        s.phase        = cwe_pkg::PH_TYPE;
                    end
                end
                cwe_pkg::PH_TYPE:
                begin
                    taken        = 1'b1;
                    s.block_type = in_byte;
                    s.cur_byte   = in_byte;
                    s.gen_busy   = 1'b1;
                    s.bit_index  = '0;
                    s.sub_index  = '0;
                    s.phase      = cwe_pkg::PH_LEN;
                end
                cwe_pkg::PH_LEN:
                begin
                    taken        = 1'b1;
                    s.block_left = in_byte;
                    s.cur_byte   = in_byte;
                    s.gen_busy   = 1'b1;
                    s.bit_index  = '0;
                    s.sub_index  = '0;
                    s.phase      = cwe_pkg::PH_BLOCK;
                end
                cwe_pkg::PH_BLOCK:
                begin
                    if (s.block_left != '0)
                    begin
                        taken        = 1'b1;
                        s.cur_byte   = in_byte;
                        s.gen_busy   = 1'b1;
                        s.bit_index  = '0;
                        s.sub_index  = '0;
                        s.block_left = s.block_left - 8'd1;
                    end
                    else
                    begin
                        s.phase = cwe_pkg::PH_SUM;
                    end
                end
                cwe_pkg::PH_SUM:
                begin
                    taken          = 1'b1;
                    s.cur_byte     = in_byte;
                    s.gen_busy     = 1'b1;
                    s.bit_index    = '0;
                    s.sub_index    = '0;
                    s.queued_byte  = cwe_pkg::LEADER_BYTE;
                    s.queued_valid = 1'b1;
                    s.phase        = cwe_pkg::PH_END;
                end
                cwe_pkg::PH_END:
                begin
                    taken = 1'b1;
                    if ((s.block_type == cwe_pkg::TYPE_EOF_LO) ||
                        (s.block_type == cwe_pkg::TYPE_EOF_HI))
                    begin
                        s.phase = cwe_pkg::PH_HEADER;
                    end
                    else
                    begin
                        s.phase = cwe_pkg::PH_SYNC;
                    end
                end
                default:
                begin
                    s.phase = cwe_pkg::PH_HEADER;
                end
            endcase
        end

        pend = (s.header_left != '0) || s.gen_busy || (s.leader_left != '0) || s.queued_valid;

        // Emit one sample: idle header first, then the bit cells of the current byte
        if (pend)
        begin
            if (s.header_left != '0)
            begin
                s.header_left = s.header_left - 12'd1;
                smp           = cfg_val.idle_level;
            end
            else
            begin
                // Load the next leader byte or the queued byte
                if (!s.gen_busy)
                begin
                    if (s.leader_left != '0)
                    begin
                        s.leader_left = s.leader_left - 8'd1;
                        s.cur_byte    = cwe_pkg::LEADER_BYTE;
                    end
                    else
                    begin
                        s.queued_valid = 1'b0;
                        s.cur_byte     = s.queued_byte;
                    end
                    s.gen_busy  = 1'b1;
                    s.bit_index = '0;
                    s.sub_index = '0;
                end

                // One is high,low; zero is high,high,low,low
                cur_bit = s.cur_byte[s.bit_index];
                if ((s.sub_index == 2'd0) || (!cur_bit && (s.sub_index == 2'd1)))
                begin
                    smp = cfg_val.high_level;
                end
                else
                begin
                    smp = cfg_val.low_level;
                end
                last = (cur_bit && (s.sub_index == 2'd1)) || (s.sub_index == 2'd3);

                if (last)
                begin
                    s.sub_index = '0;
                    if (s.bit_index == 3'd7)
                    begin
                        s.bit_index = '0;
                        s.gen_busy  = 1'b0;
                    end
                    else
                    begin
                        s.bit_index = s.bit_index + 3'd1;
                    end
                end
                else
                begin
                    s.sub_index = s.sub_index + 2'd1;
                end
            end
        end

        state_next          = s;
        result.sample_valid = pend;
        result.sample       = smp;
        result.byte_taken   = taken;
    end

    // Advance the state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

endmodule
